FILE: sv/sawbp_pkg.sv
// ----------------------------------------------------------------------------
// sawbp_pkg
// Shared types, register map and fixed-point helpers of the box placer.
// ----------------------------------------------------------------------------
`default_nettype none

package sawbp_pkg;

	// coordinate range: signed fixed point, 4 fraction bits
	localparam int COORD_BITS = 20;
	// unsigned size, margin and padding fields
	localparam int DIM_BITS = 19;
	// working width for exact sums before saturation
	localparam int XW = ((COORD_BITS > DIM_BITS + 2) ? COORD_BITS : DIM_BITS + 2) + 3;

	localparam int APB_ADDR_BITS = 5;
	localparam int APB_DATA_BITS = 32;
	localparam int REG_IDX_BITS = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_STACK_VERTICAL = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_STACK_ALIGN = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_WRAP_VERTICAL = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_PAD_LEFT = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_PAD_TOP = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_INNER_WIDTH = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_INNER_HEIGHT = 3'd6;

	localparam logic [1:0] ALIGN_START = 2'd0;
	localparam logic [1:0] ALIGN_END = 2'd1;
	localparam logic [1:0] ALIGN_CENTRE = 2'd2;

	typedef logic [DIM_BITS-1:0] dim_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [XW-1:0] wide_t;

	typedef struct packed {
		logic first_child;
		logic req_type;
		dim_t box_width;
		dim_t box_height;
		dim_t margin_left;
		dim_t margin_top;
		dim_t margin_right;
		dim_t margin_bottom;
	} box_t;

	typedef struct packed {
		coord_t offset_x;
		coord_t offset_y;
		logic line_broken;
	} place_t;

	localparam wide_t SAT_HI = {{(XW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam wide_t SAT_LO = {{(XW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

	function automatic wide_t ext_u(input dim_t v);
		return wide_t'({{(XW-DIM_BITS){1'b0}}, v});
	endfunction

	function automatic wide_t ext_s(input coord_t v);
		return wide_t'({{(XW-COORD_BITS){v[COORD_BITS-1]}}, v});
	endfunction

	// clamp to the coordinate range
	function automatic coord_t sat(input wide_t v);
		if (v > SAT_HI) begin
			return coord_t'(SAT_HI[COORD_BITS-1:0]);
		end else if (v < SAT_LO) begin
			return coord_t'(SAT_LO[COORD_BITS-1:0]);
		end
		return coord_t'(v[COORD_BITS-1:0]);
	endfunction

endpackage

`default_nettype wire

FILE: sv/stack_and_wrap_box_placer.sv
// ----------------------------------------------------------------------------
// stack_and_wrap_box_placer
// Places child boxes of one container by stacking or wrapping, one box per
// word. A box goes through the input and result registers. Throughput:
// one box per cycle unless place_stall holds the output; the running
// cursors update in the same cycle the box leaves the input register.
// Reset: config registers to their defaults (vertical stack, start align,
// row wrap, zero padding and extent); cursors and row state cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_and_wrap_box_placer (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [sawbp_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire  [sawbp_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [sawbp_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                 pready,
	input  wire                                  box_valid,
	output logic                                 box_stall,
	input  wire  sawbp_pkg::box_t                box,
	output logic                                 place_valid,
	input  wire                                  place_stall,
	output sawbp_pkg::place_t                    place
);
	import sawbp_pkg::*;

	// configuration
	logic stack_vertical_q;
	logic [1:0] stack_align_q;
	logic wrap_vertical_q;
	dim_t pad_left_q;
	dim_t pad_top_q;
	dim_t inner_width_q;
	dim_t inner_height_q;

	logic cfg_wr;
	logic [REG_IDX_BITS-1:0] cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg_idx = paddr[REG_IDX_BITS+1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_vertical_q <= 1'b1;
			stack_align_q <= ALIGN_START;
			wrap_vertical_q <= 1'b0;
			pad_left_q <= '0;
			pad_top_q <= '0;
			inner_width_q <= '0;
			inner_height_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_STACK_VERTICAL: stack_vertical_q <= pwdata[0];
				REG_STACK_ALIGN: stack_align_q <= pwdata[1:0];
				REG_WRAP_VERTICAL: wrap_vertical_q <= pwdata[0];
				REG_PAD_LEFT: pad_left_q <= pwdata[DIM_BITS-1:0];
				REG_PAD_TOP: pad_top_q <= pwdata[DIM_BITS-1:0];
				REG_INNER_WIDTH: inner_width_q <= pwdata[DIM_BITS-1:0];
				REG_INNER_HEIGHT: inner_height_q <= pwdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_STACK_VERTICAL: prdata = {{(APB_DATA_BITS-1){1'b0}}, stack_vertical_q};
			REG_STACK_ALIGN: prdata = {{(APB_DATA_BITS-2){1'b0}}, stack_align_q};
			REG_WRAP_VERTICAL: prdata = {{(APB_DATA_BITS-1){1'b0}}, wrap_vertical_q};
			REG_PAD_LEFT: prdata = {{(APB_DATA_BITS-DIM_BITS){1'b0}}, pad_left_q};
			REG_PAD_TOP: prdata = {{(APB_DATA_BITS-DIM_BITS){1'b0}}, pad_top_q};
			REG_INNER_WIDTH: prdata = {{(APB_DATA_BITS-DIM_BITS){1'b0}}, inner_width_q};
			REG_INNER_HEIGHT: prdata = {{(APB_DATA_BITS-DIM_BITS){1'b0}}, inner_height_q};
			default: prdata = '0;
		endcase
	end

	// pipeline control
	logic valid_s1;
	box_t box_s1;
	logic valid_s2;
	place_t place_s2;
	logic s2_free;
	logic adv_s1;
	logic accept;

	assign s2_free = !valid_s2 || !place_stall;
	assign adv_s1 = valid_s1 && s2_free;
	assign box_stall = valid_s1 && !s2_free;
	assign accept = box_valid && !box_stall;
	assign place_valid = valid_s2;
	assign place = place_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (!place_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			box_s1 <= box;
		end
	end

	// running placement state
	coord_t stack_cursor_q;
	coord_t wrap_cursor_x_q;
	coord_t wrap_cursor_y_q;
	coord_t line_extent_q;
	logic line_open_q;

	coord_t sc, wcx, wcy, le;
	logic lo;
	coord_t wm, hm;
	coord_t sc_n, wcx_n, wcy_n, le_n;
	logic lo_n;
	coord_t ox, oy;
	logic brk;

	// stack axis selection
	dim_t a_m0, a_sz, a_m1;
	dim_t c_pad, c_inner, c_ms;
	coord_t c_full;
	coord_t along_off;
	coord_t cross_off;
	wide_t cross_gap;

	// wrap axis selection
	coord_t w_main, w_other, w_main_len, w_cross_len;
	dim_t w_pad, w_inner;
	logic w_over;
	coord_t w_main_n, w_other_n;

	always_comb begin
		if (box_s1.first_child) begin
			sc = sat(stack_vertical_q ? ext_u(pad_top_q) : ext_u(pad_left_q));
			wcx = sat(ext_u(pad_left_q));
			wcy = sat(ext_u(pad_top_q));
			le = '0;
			lo = 1'b0;
		end else begin
			sc = stack_cursor_q;
			wcx = wrap_cursor_x_q;
			wcy = wrap_cursor_y_q;
			le = line_extent_q;
			lo = line_open_q;
		end

		wm = sat(ext_u(box_s1.margin_left) + ext_u(box_s1.box_width)
			+ ext_u(box_s1.margin_right));
		hm = sat(ext_u(box_s1.margin_top) + ext_u(box_s1.box_height)
			+ ext_u(box_s1.margin_bottom));

		// stack: along the stack direction
		a_m0 = stack_vertical_q ? box_s1.margin_top : box_s1.margin_left;
		a_sz = stack_vertical_q ? box_s1.box_height : box_s1.box_width;
		a_m1 = stack_vertical_q ? box_s1.margin_bottom : box_s1.margin_right;
		along_off = sat(ext_s(sc) + ext_u(a_m0));

		// stack: across the stack direction
		c_pad = stack_vertical_q ? pad_left_q : pad_top_q;
		c_inner = stack_vertical_q ? inner_width_q : inner_height_q;
		c_ms = stack_vertical_q ? box_s1.margin_left : box_s1.margin_top;
		c_full = stack_vertical_q ? wm : hm;
		cross_gap = ext_u(c_inner) - ext_s(c_full);
		case (stack_align_q)
			ALIGN_END: cross_off = sat(ext_u(c_pad) + cross_gap);
			ALIGN_CENTRE: cross_off = sat(ext_u(c_pad) + (cross_gap >>> 1));
			default: cross_off = sat(ext_u(c_pad) + ext_u(c_ms));
		endcase

		// wrap: main axis is the flow direction
		w_main = wrap_vertical_q ? wcy : wcx;
		w_other = wrap_vertical_q ? wcx : wcy;
		w_main_len = wrap_vertical_q ? hm : wm;
		w_cross_len = wrap_vertical_q ? wm : hm;
		w_pad = wrap_vertical_q ? pad_top_q : pad_left_q;
		w_inner = wrap_vertical_q ? inner_height_q : inner_width_q;
		w_over = (ext_s(w_main) + ext_s(w_main_len)) > (ext_u(w_inner) + ext_u(w_pad));

		sc_n = sc;
		wcx_n = wcx;
		wcy_n = wcy;
		le_n = le;
		lo_n = lo;
		brk = 1'b0;
		w_main_n = w_main;
		w_other_n = w_other;

		if (!box_s1.req_type) begin
			sc_n = sat(ext_s(sat(ext_s(along_off) + ext_u(a_sz))) + ext_u(a_m1));
			ox = stack_vertical_q ? cross_off : along_off;
			oy = stack_vertical_q ? along_off : cross_off;
		end else begin
			if (!lo) begin
				lo_n = 1'b1;
				le_n = w_cross_len;
			end else if (w_over) begin
				// break to a new row or column
				w_other_n = sat(ext_s(w_other) + ext_s(le));
				w_main_n = sat(ext_u(w_pad));
				le_n = w_cross_len;
				brk = 1'b1;
			end else if (le < w_cross_len) begin
				le_n = w_cross_len;
			end
			if (wrap_vertical_q) begin
				wcx_n = w_other_n;
				wcy_n = sat(ext_s(w_main_n) + ext_s(w_main_len));
				ox = sat(ext_s(w_other_n) + ext_u(box_s1.margin_left));
				oy = sat(ext_s(w_main_n) + ext_u(box_s1.margin_top));
			end else begin
				wcy_n = w_other_n;
				wcx_n = sat(ext_s(w_main_n) + ext_s(w_main_len));
				ox = sat(ext_s(w_main_n) + ext_u(box_s1.margin_left));
				oy = sat(ext_s(w_other_n) + ext_u(box_s1.margin_top));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_cursor_q <= '0;
			wrap_cursor_x_q <= '0;
			wrap_cursor_y_q <= '0;
			line_extent_q <= '0;
			line_open_q <= 1'b0;
		end else if (adv_s1) begin
			stack_cursor_q <= sc_n;
			wrap_cursor_x_q <= wcx_n;
			wrap_cursor_y_q <= wcy_n;
			line_extent_q <= le_n;
			line_open_q <= lo_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			place_s2.offset_x <= ox;
			place_s2.offset_y <= oy;
			place_s2.line_broken <= brk;
		end
	end

	// the input side stalls only behind a full, blocked result register
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		box_stall |-> (valid_s1 && valid_s2 && place_stall))
		else $error("input stalled with room downstream");

	// a wrap box always leaves a row open
	a_wrap_opens_row: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && box_s1.req_type |=> line_open_q)
		else $error("wrap placement left no open row");

	// stack placements never report a line break
	a_stack_no_break: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !box_s1.req_type |=> !place_s2.line_broken)
		else $error("stack placement flagged a line break");

	// a first child placed by stacking leaves the row closed
	a_first_stack_closes: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && box_s1.first_child && !box_s1.req_type |=> !line_open_q)
		else $error("row state not restarted on first child");

endmodule

`default_nettype wire
